[rtl/sequential_massart_sample_stopper_macros.svh]
// Assertion macros used by the checker of the sample stopper
`ifndef SEQUENTIAL_MASSART_SAMPLE_STOPPER_MACROS_SVH
`define SEQUENTIAL_MASSART_SAMPLE_STOPPER_MACROS_SVH
// same-cycle implication
`define SMSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sample stopper check failed");
// next-cycle implication
`define SMSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sample stopper check failed");
`endif

[rtl/smss_pkg.sv]
// Types and constants of the sequential sample stopper
package smss_pkg;
	localparam int CNT_W     = 24;
	localparam int FRAC_BITS = 24;
	localparam int EDGE_W    = 27;
	localparam int CFG_W     = 40;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_Z_SQUARED   = 3'd0;
	localparam logic [IDX_W-1:0] REG_Z_HALF      = 3'd1;
	localparam logic [IDX_W-1:0] REG_EPSILON     = 3'd2;
	localparam logic [IDX_W-1:0] REG_SCALE       = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_SAMPLES = 3'd4;

	localparam logic [28:0] Z_SQUARED_RST   = 29'd45390757;
	localparam logic [27:0] Z_HALF_RST      = 28'd32882620;
	localparam logic [23:0] EPSILON_RST     = 24'd167772;
	localparam logic [39:0] SCALE_RST       = 40'd1139474432;
	localparam logic [23:0] MAX_SAMPLES_RST = 24'd18445;

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_ACCEPT   = 4'd1;
	localparam logic [3:0] OP_DIV_MEAN = 4'd2;
	localparam logic [3:0] OP_DIV_STEP = 4'd3;
	localparam logic [3:0] OP_MEAN     = 4'd4;
	localparam logic [3:0] OP_VAR_MUL  = 4'd5;
	localparam logic [3:0] OP_DIV_VAR  = 4'd6;
	localparam logic [3:0] OP_SQ_INIT  = 4'd7;
	localparam logic [3:0] OP_SQ_STEP  = 4'd8;
	localparam logic [3:0] OP_SIG_MUL  = 4'd9;
	localparam logic [3:0] OP_EDGE     = 4'd10;
	localparam logic [3:0] OP_AB_MUL   = 4'd11;
	localparam logic [3:0] OP_P_STORE  = 4'd12;
	localparam logic [3:0] OP_PP       = 4'd13;
	localparam logic [3:0] OP_FINAL    = 4'd14;
	localparam logic [3:0] OP_OUT      = 4'd15;

	typedef struct packed {
		logic [3:0] op;
		logic [2:0] idx;
	} ctl_t;

	typedef struct packed {
		logic finished;
	} stat_t;
endpackage

[rtl/sequential_massart_sample_stopper.sv]
// Sequential sample stopper: score interval and Massart bound, one request at a time.
// A record request has its result in the output register after the shared restoring
// divider (two 24-step divisions), the 24-step square root and the four partial products
// of the 40-bit scale multiply; a restart, or a record once done, goes from acceptance
// straight to the output step. The next request can be taken the cycle after the previous
// result has moved into the output register, which holds it while the consumer stalls.
module sequential_massart_sample_stopper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic                          success,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smss_pkg::CNT_W-1:0]    success_total,
	output logic [smss_pkg::CNT_W-1:0]    sample_total,
	output logic [smss_pkg::CNT_W-1:0]    needed_samples,
	output logic signed [smss_pkg::EDGE_W-1:0] lower_bound,
	output logic signed [smss_pkg::EDGE_W-1:0] upper_edge,
	output logic                          done_res,
	input  logic                          cfg_we,
	input  logic [smss_pkg::IDX_W-1:0]    cfg_index,
	input  logic [smss_pkg::CFG_W-1:0]    cfg_data
);
	smss_pkg::ctl_t  ctl;
	smss_pkg::stat_t stat;

	smss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	smss_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.cmd            (cmd),
		.success        (success),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.success_total  (success_total),
		.sample_total   (sample_total),
		.needed_samples (needed_samples),
		.lower_bound    (lower_bound),
		.upper_edge     (upper_edge),
		.done_res       (done_res)
	);
endmodule

[rtl/smss_ctrl.sv]
// Sequencer of the sample stopper: handshakes and datapath commands
module smss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cmd,
	output logic           out_valid,
	input  logic           out_stall,
	input  smss_pkg::stat_t stat,
	output smss_pkg::ctl_t  ctl
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVM  = 4'd1;
	localparam logic [3:0] S_STPM  = 4'd2;
	localparam logic [3:0] S_MEAN  = 4'd3;
	localparam logic [3:0] S_VARM  = 4'd4;
	localparam logic [3:0] S_DIVV  = 4'd5;
	localparam logic [3:0] S_STPV  = 4'd6;
	localparam logic [3:0] S_SQI   = 4'd7;
	localparam logic [3:0] S_SQS   = 4'd8;
	localparam logic [3:0] S_SIG   = 4'd9;
	localparam logic [3:0] S_EDGE  = 4'd10;
	localparam logic [3:0] S_AB    = 4'd11;
	localparam logic [3:0] S_PST   = 4'd12;
	localparam logic [3:0] S_PP    = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;
	localparam logic [3:0] S_OUT   = 4'd15;

	logic [3:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       ov_d;
	logic       last;

	assign in_stall = (state_q != S_IDLE);
	assign last     = (cnt_q == 5'd23);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ov_d    = out_valid && out_stall;
		ctl.op  = smss_pkg::OP_NONE;
		ctl.idx = cnt_q[2:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = smss_pkg::OP_ACCEPT;
					state_d = (cmd || stat.finished) ? S_OUT : S_DIVM;
				end
			end
			S_DIVM: begin
				ctl.op  = smss_pkg::OP_DIV_MEAN;
				cnt_d   = '0;
				state_d = S_STPM;
			end
			S_STPM: begin
				ctl.op = smss_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (last) state_d = S_MEAN;
			end
			S_MEAN: begin
				ctl.op  = smss_pkg::OP_MEAN;
				state_d = S_VARM;
			end
			S_VARM: begin
				ctl.op  = smss_pkg::OP_VAR_MUL;
				state_d = S_DIVV;
			end
			S_DIVV: begin
				ctl.op  = smss_pkg::OP_DIV_VAR;
				cnt_d   = '0;
				state_d = S_STPV;
			end
			S_STPV: begin
				ctl.op = smss_pkg::OP_DIV_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (last) state_d = S_SQI;
			end
			S_SQI: begin
				ctl.op  = smss_pkg::OP_SQ_INIT;
				cnt_d   = '0;
				state_d = S_SQS;
			end
			S_SQS: begin
				ctl.op = smss_pkg::OP_SQ_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (last) state_d = S_SIG;
			end
			S_SIG: begin
				ctl.op  = smss_pkg::OP_SIG_MUL;
				state_d = S_EDGE;
			end
			S_EDGE: begin
				ctl.op  = smss_pkg::OP_EDGE;
				state_d = S_AB;
			end
			S_AB: begin
				ctl.op  = smss_pkg::OP_AB_MUL;
				state_d = S_PST;
			end
			S_PST: begin
				ctl.op  = smss_pkg::OP_P_STORE;
				cnt_d   = '0;
				state_d = S_PP;
			end
			S_PP: begin
				ctl.op = smss_pkg::OP_PP;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == 5'd4) state_d = S_FIN;
			end
			S_FIN: begin
				ctl.op  = smss_pkg::OP_FINAL;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!(out_valid && out_stall)) begin
					ctl.op  = smss_pkg::OP_OUT;
					ov_d    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			out_valid <= ov_d;
		end
	end
endmodule

[rtl/smss_dp.sv]
// Datapath of the sample stopper: counts, divider, square root, multiplier, bound
module smss_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  smss_pkg::ctl_t                ctl,
	output smss_pkg::stat_t               stat,
	input  logic                          cmd,
	input  logic                          success,
	input  logic                          cfg_we,
	input  logic [smss_pkg::IDX_W-1:0]    cfg_index,
	input  logic [smss_pkg::CFG_W-1:0]    cfg_data,
	output logic [smss_pkg::CNT_W-1:0]    success_total,
	output logic [smss_pkg::CNT_W-1:0]    sample_total,
	output logic [smss_pkg::CNT_W-1:0]    needed_samples,
	output logic signed [smss_pkg::EDGE_W-1:0] lower_bound,
	output logic signed [smss_pkg::EDGE_W-1:0] upper_edge,
	output logic                          done_res
);
	localparam int F = smss_pkg::FRAC_BITS;
	localparam int C = smss_pkg::CNT_W;
	localparam logic [1:0] K_MASS = 2'd0;
	localparam logic [1:0] K_MAX  = 2'd1;
	localparam logic [1:0] K_ZERO = 2'd2;
	localparam logic signed [29:0] ONE_S  = 30'sd1 <<< F;
	localparam logic signed [29:0] TWO_S  = 30'sd2 <<< F;
	localparam logic signed [29:0] HALF_S = 30'sd1 <<< (F - 1);

	logic [28:0] zsq_q;
	logic [27:0] zhalf_q;
	logic [23:0] eps_q;
	logic [39:0] scale_q;
	logic [23:0] maxs_q;

	logic [C-1:0] m_q, k_q, need_q;
	logic signed [smss_pkg::EDGE_W-1:0] low_q, high_q;
	logic fin_q;

	logic [48:0] den_q, r_q;
	logic [24:0] q_q, mean_q;
	logic [47:0] sx_q, res_q, bit_q;
	logic [63:0] mp_q;
	logic [53:0] p_q;
	logic [93:0] acc_q;
	logic [26:0] a_q, b_q;
	logic [1:0]  kind_q;

	logic [48:0] den_c, num_c, r_nx;
	logic [49:0] rs;
	logic [47:0] sq_t;
	logic [31:0] ma, mb;
	logic [27:0] sigma_c;
	logic signed [29:0] mean_s, lo_c, hi_c, g_c, a_c, b_c;
	logic [93:0] pp_sh;
	logic [29:0] mres;
	logic [30:0] mcap;
	logic [C-1:0] need_c;

	assign stat.finished = fin_q;

	assign den_c = {1'b0, k_q, {F{1'b0}}} + 49'(zsq_q);
	assign num_c = {1'b0, m_q, {F{1'b0}}} + 49'(zsq_q >> 1);
	assign rs    = {r_q, 1'b0};
	assign r_nx  = 49'(rs - {1'b0, den_q});
	assign sq_t  = res_q + bit_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (ctl.op)
			smss_pkg::OP_VAR_MUL: begin
				ma = 32'(mean_q);
				mb = 32'((25'd1 << F) - mean_q);
			end
			smss_pkg::OP_SIG_MUL: begin
				ma = 32'(zhalf_q);
				mb = 32'(res_q[23:0]);
			end
			smss_pkg::OP_AB_MUL: begin
				ma = 32'(a_q);
				mb = 32'(b_q);
			end
			smss_pkg::OP_PP: begin
				ma = ctl.idx[1] ? 32'(scale_q[39:20]) : 32'(scale_q[19:0]);
				mb = ctl.idx[0] ? 32'(p_q[53:27]) : 32'(p_q[26:0]);
			end
			default: ;
		endcase
	end

	// shift of the partial product that finished in the previous cycle
	always_comb begin
		case (ctl.idx)
			3'd1: pp_sh = 94'(mp_q);
			3'd2: pp_sh = 94'(mp_q) << 27;
			3'd3: pp_sh = 94'(mp_q) << 20;
			3'd4: pp_sh = 94'(mp_q) << 47;
			default: pp_sh = '0;
		endcase
	end

	always_comb begin
		sigma_c = mp_q[51:24];
		if (sigma_c > 28'(4 << F)) sigma_c = 28'(4 << F);
		mean_s = 30'(mean_q);
		lo_c = mean_s - 30'(sigma_c);
		hi_c = mean_s + 30'(sigma_c);
		if (lo_c < -ONE_S) lo_c = -ONE_S;
		if (hi_c > TWO_S) hi_c = TWO_S;
		g_c = (hi_c < HALF_S) ? hi_c : lo_c;
		if (g_c < HALF_S) begin
			a_c = 30'sd3 * g_c + 30'(eps_q);
			b_c = 30'sd3 * (ONE_S - g_c) - 30'(eps_q);
		end else begin
			a_c = 30'sd3 * (ONE_S - g_c) + 30'(eps_q);
			b_c = 30'sd3 * g_c + 30'(eps_q);
		end
	end

	assign mres = acc_q[93:64] + 30'(acc_q[63:0] != 64'd0);
	assign mcap = 31'(mres);
	always_comb begin
		case (kind_q)
			K_MASS:  need_c = (mcap > 31'(maxs_q)) ? maxs_q : mres[C-1:0];
			K_MAX:   need_c = maxs_q;
			default: need_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zsq_q   <= smss_pkg::Z_SQUARED_RST;
			zhalf_q <= smss_pkg::Z_HALF_RST;
			eps_q   <= smss_pkg::EPSILON_RST;
			scale_q <= smss_pkg::SCALE_RST;
			maxs_q  <= smss_pkg::MAX_SAMPLES_RST;
			m_q     <= '0;
			k_q     <= '0;
			need_q  <= smss_pkg::MAX_SAMPLES_RST;
			low_q   <= '0;
			high_q  <= 27'sd1 <<< F;
			fin_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					smss_pkg::REG_Z_SQUARED:   zsq_q   <= cfg_data[28:0];
					smss_pkg::REG_Z_HALF:      zhalf_q <= cfg_data[27:0];
					smss_pkg::REG_EPSILON:     eps_q   <= cfg_data[23:0];
					smss_pkg::REG_SCALE:       scale_q <= cfg_data[39:0];
					smss_pkg::REG_MAX_SAMPLES: maxs_q  <= cfg_data[23:0];
					default: ;
				endcase
			end
			case (ctl.op)
				smss_pkg::OP_ACCEPT: begin
					if (cmd) begin
						m_q    <= '0;
						k_q    <= '0;
						need_q <= maxs_q;
						low_q  <= '0;
						high_q <= 27'sd1 <<< F;
						fin_q  <= 1'b0;
					end else if (!fin_q) begin
						if (k_q != '1) k_q <= k_q + 1'b1;
						if (success && m_q != '1) m_q <= m_q + 1'b1;
					end
				end
				smss_pkg::OP_EDGE: begin
					low_q  <= lo_c[26:0];
					high_q <= hi_c[26:0];
				end
				smss_pkg::OP_FINAL: begin
					need_q <= need_c;
					fin_q  <= (k_q >= need_c);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			smss_pkg::OP_DIV_MEAN: begin
				den_q <= den_c;
				if (num_c >= den_c) begin
					r_q <= num_c - den_c;
					q_q <= 25'd1;
				end else begin
					r_q <= num_c;
					q_q <= 25'd0;
				end
			end
			smss_pkg::OP_DIV_STEP: begin
				if (rs >= {1'b0, den_q}) begin
					r_q <= r_nx;
					q_q <= {q_q[23:0], 1'b1};
				end else begin
					r_q <= rs[48:0];
					q_q <= {q_q[23:0], 1'b0};
				end
			end
			smss_pkg::OP_MEAN: mean_q <= (q_q > (25'd1 << F)) ? (25'd1 << F) : q_q;
			smss_pkg::OP_DIV_VAR: begin
				r_q <= 49'(mp_q[47:24]);
				q_q <= '0;
			end
			smss_pkg::OP_SQ_INIT: begin
				sx_q  <= {q_q[23:0], {F{1'b0}}};
				res_q <= '0;
				bit_q <= {2'b01, 46'd0};
			end
			smss_pkg::OP_SQ_STEP: begin
				if (sx_q >= sq_t) begin
					sx_q  <= sx_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			smss_pkg::OP_EDGE: begin
				a_q <= a_c[26:0];
				b_q <= b_c[26:0];
				if (lo_c <= HALF_S && HALF_S <= hi_c) kind_q <= K_MAX;
				else if (g_c >= ONE_S) kind_q <= K_MAX;
				else if (a_c <= 0 || b_c <= 0) kind_q <= K_ZERO;
				else kind_q <= K_MASS;
			end
			smss_pkg::OP_P_STORE: begin
				p_q   <= mp_q[53:0];
				acc_q <= '0;
			end
			smss_pkg::OP_PP: acc_q <= acc_q + pp_sh;
			smss_pkg::OP_OUT: begin
				success_total  <= m_q;
				sample_total   <= k_q;
				needed_samples <= need_q;
				lower_bound    <= low_q;
				upper_edge     <= high_q;
				done_res       <= fin_q;
			end
			default: ;
		endcase
		mp_q <= ma * mb;
	end
endmodule

[rtl/smss_checker.sv]
// Port-level checks of the sample stopper and their binding
`include "sequential_massart_sample_stopper_macros.svh"
module smss_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [smss_pkg::CNT_W-1:0]    sample_total,
	input logic [smss_pkg::CNT_W-1:0]    needed_samples,
	input logic signed [smss_pkg::EDGE_W-1:0] lower_bound,
	input logic signed [smss_pkg::EDGE_W-1:0] upper_edge,
	input logic                          done_res
);
	// one request in flight at a time
	`SMSS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`SMSS_ASSERT_NXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid)
	`SMSS_ASSERT_IMP(a_done_count, clk, arst_n, out_valid && done_res, sample_total >= needed_samples)
	`SMSS_ASSERT_IMP(a_edges_ordered, clk, arst_n, out_valid, lower_bound <= upper_edge)
endmodule

bind sequential_massart_sample_stopper smss_checker u_smss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.sample_total   (sample_total),
	.needed_samples (needed_samples),
	.lower_bound    (lower_bound),
	.upper_edge     (upper_edge),
	.done_res       (done_res)
);
